// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers for the RTL; empty when SYNTH is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked property, disabled while reset is high.
`define PHHP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
// Clocked property, checked during reset too.
`define PHHP_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define PHHP_ASSERT(lbl, clk, rst, prop)
`define PHHP_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== sv/phhp_pkg.sv =====
// ----------------------------------------------------------------------------
// phhp_pkg
// Types, codes and character decode for the prefixed hex hash parser.
// ----------------------------------------------------------------------------
`default_nettype none

package phhp_pkg;

  localparam int HASH_BYTES_DEF = 32;

  localparam int TAG_LEN  = 4;
  localparam int HEAD_LEN = 7;

  // Expected tag, first character first
  localparam logic [7:0] TAG_CHARS [TAG_LEN] = '{8'h52, 8'h49, 8'h48, 8'h53};

  localparam logic [7:0] POS_MAX = 8'hff;

  // Early error codes
  localparam logic [2:0] ERR_NONE   = 3'd0;
  localparam logic [2:0] ERR_PREFIX = 3'd1;
  localparam logic [2:0] ERR_DIGIT  = 3'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_PREFIX  = 3'd1;
  localparam logic [2:0] ST_SHORT   = 3'd2;
  localparam logic [2:0] ST_DIGITS  = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;
  localparam logic [2:0] ST_LENGTH  = 3'd5;
  localparam logic [2:0] ST_NONHEX  = 3'd6;

  localparam logic [7:0] VER_ONE = 8'd1;
  localparam logic [7:0] VER_TWO = 8'd2;

  typedef struct packed {
    logic [7:0] character;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic       is_status;
    logic [7:0] byte_value;
    logic [4:0] byte_index;
    logic [2:0] status;
    logic [7:0] version;
  } out_item_t;

  // Decode one hex digit of either case; bit 4 set means not a hex digit.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    begin
      r = 5'b1_0000;
      if (c inside {[8'h30:8'h39]}) begin
        r = {1'b0, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
        r = {1'b0, c[3:0] + 4'h9};
      end
      return r;
    end
  endfunction

endpackage

`default_nettype wire

// ===== sv/phhp_stream_if.sv =====
// ----------------------------------------------------------------------------
// phhp_stream_if
// Valid/ready channel carrying one payload item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface phhp_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/phhp_in_stage.sv =====
// ----------------------------------------------------------------------------
// phhp_in_stage
// Input register: captures one character item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module phhp_in_stage
  import phhp_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  phhp_stream_if.sink   chars,
  phhp_stream_if.source staged
);

  logic     valid;
  in_item_t item;

  // Take a new item whenever the held one leaves or none is held
  assign chars.ready  = !valid || staged.ready;
  assign staged.valid = valid;
  assign staged.data  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chars.ready) begin
      valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      item <= chars.data;
    end
  end

endmodule

`default_nettype wire

// ===== sv/phhp_core.sv =====
// ----------------------------------------------------------------------------
// phhp_core
// Parse state, per-character checks and byte assembly, result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module phhp_core
  import phhp_pkg::*;
#(
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  wire          clk,
  input  wire          rst,
  phhp_stream_if.sink   staged,
  phhp_stream_if.source results
);

  localparam logic [7:0] VS_FULL = 8'(HASH_BYTES);
  localparam logic [7:0] VS_HALF = 8'(HASH_BYTES / 2);

  logic [7:0] char_position, char_position_next;
  logic [2:0] early_error, early_error_next;
  logic [7:0] parsed_version, parsed_version_next;
  logic [3:0] pending_high_nibble, pending_high_nibble_next;
  logic       value_digit_error, value_digit_error_next;

  logic      out_valid;
  out_item_t out_item;

  logic      advance;
  logic      emit;
  out_item_t res;

  logic [7:0] c;
  logic [4:0] nib;
  logic [7:0] vs;
  logic [8:0] expected_len;
  logic [7:0] k;
  logic [6:0] idx;
  logic       vde_new;

  assign staged.ready  = !out_valid || results.ready;
  assign advance       = staged.valid && staged.ready;
  assign results.valid = out_valid;
  assign results.data  = out_item;

  always_comb begin
    c   = staged.data.character;
    nib = hex_decode(c);
    if (parsed_version == VER_ONE) begin
      vs = VS_FULL;
    end else if (parsed_version == VER_TWO) begin
      vs = VS_HALF;
    end else begin
      vs = 8'd0;
    end
    expected_len = 9'(HEAD_LEN) + {vs, 1'b0};
    k   = char_position - 8'(HEAD_LEN);
    idx = k[7:1];
    vde_new = value_digit_error || nib[4];

    char_position_next       = char_position;
    early_error_next         = early_error;
    parsed_version_next      = parsed_version;
    pending_high_nibble_next = pending_high_nibble;
    value_digit_error_next   = value_digit_error;
    emit = 1'b0;
    res  = '0;

    if (staged.data.end_of_string) begin
      emit = 1'b1;
      res.is_status = 1'b1;
      if (early_error == ERR_PREFIX || char_position < 8'(TAG_LEN)) begin
        res.status = ST_PREFIX;
      end else if (char_position < 8'(HEAD_LEN)) begin
        res.status = ST_SHORT;
      end else if (early_error != ERR_NONE) begin
        res.status = ST_DIGITS;
      end else begin
        res.version = parsed_version;
        if (vs == 8'd0) begin
          res.status = ST_UNKNOWN;
        end else if ({1'b0, char_position} != expected_len) begin
          res.status = ST_LENGTH;
        end else if (value_digit_error) begin
          res.status = ST_NONHEX;
        end else begin
          res.status = ST_OK;
        end
      end
      // Clear for the next string
      char_position_next       = '0;
      early_error_next         = ERR_NONE;
      parsed_version_next      = '0;
      pending_high_nibble_next = '0;
      value_digit_error_next   = 1'b0;
    end else begin
      if (char_position != POS_MAX) begin
        char_position_next = char_position + 8'd1;
      end
      if (char_position < 8'(TAG_LEN)) begin
        if (c != TAG_CHARS[char_position[1:0]] && early_error == ERR_NONE) begin
          early_error_next = ERR_PREFIX;
        end
      end else if (char_position < 8'(HEAD_LEN - 1)) begin
        if (nib[4]) begin
          if (early_error == ERR_NONE) begin
            early_error_next = ERR_DIGIT;
          end
        end else if (char_position == 8'(TAG_LEN)) begin
          parsed_version_next = {nib[3:0], 4'h0};
        end else begin
          parsed_version_next = {parsed_version[7:4], nib[3:0]};
        end
      end else if (char_position >= 8'(HEAD_LEN)) begin
        if (!k[0]) begin
          if (nib[4]) begin
            value_digit_error_next = 1'b1;
          end else begin
            pending_high_nibble_next = nib[3:0];
          end
        end else begin
          value_digit_error_next = vde_new;
          if (early_error == ERR_NONE && vs != 8'd0 && {1'b0, idx} < vs && !vde_new) begin
            emit = 1'b1;
            res.byte_value = {pending_high_nibble, nib[3:0]};
            res.byte_index = idx[4:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position       <= '0;
      early_error         <= ERR_NONE;
      parsed_version      <= '0;
      pending_high_nibble <= '0;
      value_digit_error   <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      if (advance) begin
        char_position       <= char_position_next;
        early_error         <= early_error_next;
        parsed_version      <= parsed_version_next;
        pending_high_nibble <= pending_high_nibble_next;
        value_digit_error   <= value_digit_error_next;
      end
      if (staged.ready) begin
        out_valid <= staged.valid && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_item <= res;
    end
  end

  // End marker leaves the parser cleared
  `PHHP_ASSERT(a_clear_after_end, clk, rst,
    (advance && staged.data.end_of_string) |=> (char_position == 8'd0 && early_error == ERR_NONE))
  // A byte waiting at the output was produced with no early error
  `PHHP_ASSERT(a_byte_no_early_err, clk, rst,
    (out_valid && !out_item.is_status) |-> (early_error == ERR_NONE))
  // Position holds at saturation while characters keep coming
  `PHHP_ASSERT(a_pos_saturates, clk, rst,
    (advance && !staged.data.end_of_string && char_position == POS_MAX) |=>
      (char_position == POS_MAX))

endmodule

`default_nettype wire

// ===== sv/prefixed_hex_hash_parser_top.sv =====
// Prefixed hex hash parser: one character transfer per cycle in while the result side
// does not stall, bytes and status out. A character passes the input register, then
// the result register, which loads as the core takes the character; a character that
// yields no result loads nothing there. Parse state updates as each character is taken.
// Reset: synchronous, active high; clears parse state and both valid flags.
`default_nettype none

module prefixed_hex_hash_parser_top
  import phhp_pkg::*;
#(
  // Value length in bytes for version 1; version 2 carries half
  parameter int HASH_BYTES = HASH_BYTES_DEF
) (
  input  wire          clk,
  input  wire          rst,
  phhp_stream_if.sink   chars,
  phhp_stream_if.source results
);

  // Internal channel between the input register and the parse core
  phhp_stream_if #(.T(in_item_t)) staged ();

  // Hold each accepted character until the core takes it
  phhp_in_stage u_in_stage (
    .clk    (clk),
    .rst    (rst),
    .chars  (chars),
    .staged (staged)
  );

  // Check tag and version, assemble value bytes, report status at the end marker;
  // the result register frees the input side as soon as its item is taken
  phhp_core #(
    .HASH_BYTES (HASH_BYTES)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .staged  (staged),
    .results (results)
  );

endmodule

`default_nettype wire

// ===== bench/hash_check_pkg.sv =====
// ----------------------------------------------------------------------------
// hash_check_pkg
// Scoreboard for the hex hash parser: predicts the byte and status transfers
// that each accepted character causes, and checks results against them.
// ----------------------------------------------------------------------------
package hash_check_pkg;
  import phhp_pkg::*;

  class hash_string_checker;
    int unsigned hash_bytes;
    int unsigned mismatch_count;
    out_item_t   due_results[$];

    // Parse state, mirrored from the block
    logic [7:0]  position;
    logic [2:0]  early_err;
    logic [7:0]  version_seen;
    logic [3:0]  high_digit;
    logic        bad_value_digit;

    function new(int unsigned bytes_v1);
      hash_bytes = bytes_v1;
      mismatch_count = 0;
      clear_parse();
    endfunction

    function void clear_parse();
      position = '0;
      early_err = ERR_NONE;
      version_seen = '0;
      high_digit = '0;
      bad_value_digit = 1'b0;
    endfunction

    function int unsigned bytes_for_version(logic [7:0] v);
      if (v == VER_ONE) return hash_bytes;
      if (v == VER_TWO) return hash_bytes / 2;
      return 0;
    endfunction

    // Digit value of a hex character, -1 for anything else
    function int digit_of(logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
      if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
      return -1;
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    // Advance the parse by one accepted character transfer
    function void take_char(in_item_t item);
      out_item_t   r;
      int          d;
      int          k;
      int unsigned vs;
      logic [7:0]  p;
      p  = position;
      d  = digit_of(item.character);
      vs = bytes_for_version(version_seen);
      r  = '0;
      if (item.end_of_string) begin
        r.is_status = 1'b1;
        if (early_err == ERR_PREFIX || p < TAG_LEN) begin
          r.status = ST_PREFIX;
        end else if (p < HEAD_LEN) begin
          r.status = ST_SHORT;
        end else if (early_err != ERR_NONE) begin
          r.status = ST_DIGITS;
        end else begin
          r.version = version_seen;
          if (vs == 0) r.status = ST_UNKNOWN;
          else if (p != HEAD_LEN + 2 * vs) r.status = ST_LENGTH;
          else if (bad_value_digit) r.status = ST_NONHEX;
          else r.status = ST_OK;
        end
        due_results.push_back(r);
        clear_parse();
        return;
      end
      if (position != POS_MAX) position = position + 8'd1;
      if (p < TAG_LEN) begin
        if (item.character != TAG_CHARS[p] && early_err == ERR_NONE) early_err = ERR_PREFIX;
      end else if (p < TAG_LEN + 2) begin
        if (d < 0) begin
          if (early_err == ERR_NONE) early_err = ERR_DIGIT;
        end else if (p == TAG_LEN) begin
          version_seen = {d[3:0], 4'h0};
        end else begin
          version_seen[3:0] = d[3:0];
        end
      end else if (p >= HEAD_LEN) begin
        k = p - HEAD_LEN;
        if (d < 0) bad_value_digit = 1'b1;
        if (k % 2 == 0) begin
          if (d >= 0) high_digit = d[3:0];
        end else if (early_err == ERR_NONE && vs != 0 && k / 2 < vs && !bad_value_digit) begin
          r.byte_value = {high_digit, d[3:0]};
          r.byte_index = 5'(k / 2);
          due_results.push_back(r);
        end
      end
    endfunction

    task report(string what);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    task match_result(out_item_t got);
      out_item_t want;
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result %h", got));
        return;
      end
      want = due_results.pop_front();
      if (got.is_status != want.is_status)
        report($sformatf("is_status got %0h want %0h", got.is_status, want.is_status));
      if (got.byte_value != want.byte_value)
        report($sformatf("byte_value got %0h want %0h", got.byte_value, want.byte_value));
      if (got.byte_index != want.byte_index)
        report($sformatf("byte_index got %0d want %0d", got.byte_index, want.byte_index));
      if (got.status != want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.version != want.version)
        report($sformatf("version got %0h want %0h", got.version, want.version));
    endtask

    task check_drained();
      if (due_results.size() != 0)
        report($sformatf("%0d results never arrived", due_results.size()));
    endtask
  endclass

endpackage

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives hash strings into the hex hash parser one character transfer at a
// time, with bursty input and a stalling result sink, and checks every byte
// and status transfer against a scoreboard prediction.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import phhp_pkg::*;
  import hash_check_pkg::*;

  localparam int HASH_BYTES   = HASH_BYTES_DEF;
  localparam int RANDOM_ITEMS = 360;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_COMB} rx_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  phhp_stream_if #(.T(in_item_t))  chars_if ();
  phhp_stream_if #(.T(out_item_t)) results_if ();

  prefixed_hex_hash_parser_top #(.HASH_BYTES(HASH_BYTES)) u_top (
    .clk     (clk),
    .rst     (rst),
    .chars   (chars_if),
    .results (results_if)
  );

  always #1 clk = ~clk;

  hash_string_checker sb = new(HASH_BYTES);

  // Characters of the string being assembled, sent as one string
  logic [7:0] char_q[$];
  int         burst_left = 0;
  int         items_sent = 0;
  rx_mode_t   stall_mode = RX_OPEN;
  int         stall_tick = 0;

  // Result sink: hold each stall pattern for a random stretch, then pick
  // another. The open mode gives stretches with no back-pressure at all.
  always @(posedge clk) begin
    if (stall_tick == 0) begin
      stall_mode <= rx_mode_t'($urandom_range(0, 2));
      stall_tick <= $urandom_range(20, 80);
    end else begin
      stall_tick <= stall_tick - 1;
    end
    case (stall_mode)
      RX_OPEN: results_if.ready <= 1'b1;
      RX_COIN: results_if.ready <= ($urandom_range(0, 1) == 1);
      default: results_if.ready <= (stall_tick % 5 >= 2);
    endcase
  end

  // Check every result transfer as it completes
  always @(posedge clk) begin
    if (!rst && results_if.valid && results_if.ready) sb.match_result(results_if.data);
  end

  // Offer one character transfer and wait for it to be taken. Between bursts,
  // drop valid before the next transfer; within a burst keep valid high so that
  // back-to-back transfers are exercised.
  task automatic send_char(input logic [7:0] c, input logic eos);
    in_item_t item;
    item.character     = c;
    item.end_of_string = eos;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      chars_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    burst_left--;
    chars_if.valid <= 1'b1;
    chars_if.data  <= item;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    sb.take_char(item);
    items_sent++;
  endtask

  // Send the assembled string, then the end marker with a random character
  task automatic send_text();
    foreach (char_q[i]) send_char(char_q[i], 1'b0);
    send_char(8'($urandom_range(0, 255)), 1'b1);
    char_q.delete();
  endtask

  task automatic push_tag();
    for (int i = 0; i < TAG_LEN; i++) char_q.push_back(TAG_CHARS[i]);
  endtask

  // Hex character of a nibble, letters in either case
  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'h30 + 8'(n);
    return (($urandom_range(0, 1) == 1) ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
  endfunction

  // Non-hex characters, weighted to the edges of the digit and letter ranges
  function automatic logic [7:0] junk_char();
    case ($urandom_range(0, 8))
      0: return 8'h00;
      1: return 8'hff;
      2: return 8'h2f;
      3: return 8'h3a;
      4: return 8'h40;
      5: return 8'h47;
      6: return 8'h60;
      7: return 8'h67;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_header(input logic [7:0] ver);
    push_tag();
    char_q.push_back(hex_char(ver[7:4]));
    char_q.push_back(hex_char(ver[3:0]));
    // The separator is never checked, so vary it now and then
    char_q.push_back(($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : 8'h5f);
  endtask

  // Mostly well-formed strings with random content; some of them broken by
  // one mutation, the rest tag-led junk or plain noise.
  task automatic make_random_string();
    int         kind;
    int         n;
    int         cut;
    logic [7:0] ver;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: ver = VER_TWO;
        6, 7, 8: ver = VER_ONE;
        default: ver = 8'($urandom_range(0, 255));
      endcase
      n = (ver == VER_ONE) ? HASH_BYTES : (ver == VER_TWO) ? HASH_BYTES / 2 : $urandom_range(0, 4);
      push_header(ver);
      repeat (2 * n) char_q.push_back(hex_char(4'($urandom_range(0, 15))));
      case ($urandom_range(0, 9))
        0: char_q[$urandom_range(0, char_q.size() - 1)] = junk_char();
        1: begin
          if (char_q.size() > HEAD_LEN)
            char_q[$urandom_range(HEAD_LEN, char_q.size() - 1)] = junk_char();
        end
        2: repeat ($urandom_range(1, 3)) void'(char_q.pop_back());
        3: repeat ($urandom_range(1, 3)) char_q.push_back(hex_char(4'($urandom_range(0, 15))));
        4: begin
          cut = $urandom_range(0, HEAD_LEN + 1);
          while (char_q.size() > cut) void'(char_q.pop_back());
        end
        default: ;
      endcase
    end else if (kind < 90) begin
      push_tag();
      repeat ($urandom_range(0, 20))
        char_q.push_back(($urandom_range(0, 1) == 1) ? hex_char(4'($urandom_range(0, 15)))
                                                    : 8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(0, 12)) char_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int random_start;
    chars_if.valid   = 1'b0;
    chars_if.data    = '0;
    results_if.ready = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty string, cut-off tag, cut-off version, bad version digit
    // at the top code, unknown version with a zero separator character
    send_text();
    for (int i = 0; i < TAG_LEN - 1; i++) char_q.push_back(TAG_CHARS[i]);
    send_text();
    push_tag();
    char_q.push_back(8'h30);
    send_text();
    push_tag();
    char_q.push_back(8'hff);
    char_q.push_back(8'h31);
    char_q.push_back(8'h5f);
    send_text();
    push_tag();
    char_q.push_back(8'h30);
    char_q.push_back(8'h33);
    char_q.push_back(8'h00);
    send_text();

    // One overlong version-one string to drive the position into saturation
    push_header(VER_ONE);
    while (char_q.size() < 262) char_q.push_back(hex_char(4'($urandom_range(0, 15))));
    send_text();

    random_start = items_sent;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      make_random_string();
      send_text();
    end
    chars_if.valid <= 1'b0;

    // Drain, then allow the two-stage pipeline to settle before the verdict
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    sb.check_drained();
    if (sb.mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run
  initial begin
    #1_000_000;
    $display("tb_top failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+sv
sv/phhp_pkg.sv
sv/phhp_stream_if.sv
sv/phhp_in_stage.sv
sv/phhp_core.sv
sv/prefixed_hex_hash_parser_top.sv
bench/hash_check_pkg.sv
bench/tb_top.sv
